// ===== src/qsmp_pkg.sv =====
// Shared constants and the controller state type for the quicksort core.
package qsmp_pkg;

   // Width of one element and default buffer depth.
   localparam int DATA_W       = 32;
   localparam int CAPACITY_DEF = 32;

   // Controller states: load, partition sequencer, range stack and drain.
   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_POP,
      ST_POP_WAIT,
      ST_RD_MID,
      ST_RD_LO,
      ST_SWAP_MID,
      ST_SWAP_LO,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_FIN_RD,
      ST_FIN_A,
      ST_FIN_B,
      ST_PUSH_R,
      ST_PUSH_L,
      ST_OUT_RD,
      ST_OUT
   } state_type;

endpackage

// ===== src/quicksort_middle_pivot_core.sv =====
// Quicksort core: collects a set of signed values, sorts them in place, streams them out.
//
//   Channel | Ports                                         | Direction
//   --------+-----------------------------------------------+----------
//   request | req_valid, req_ready, req_value, req_last     | in
//   result  | rsp_valid, rsp_ready, rsp_sorted_value,       | out
//           | rsp_final_res, rsp_overflow                   |
//
// Loading accepts one request per cycle; the request flagged last starts the sort.
// Each range is set up with its middle element as pivot, scanned element by element with a swap
// only for two distinct entries, and closed by moving the pivot unless it stays at the front, all
// through the one element memory port. With the stack empty, results leave at one per cycle while
// rsp_ready is high; no request is taken until the final result of the run is accepted.
// Reset is synchronous and clears the controller and counts; a stall only delays the drain.
module quicksort_middle_pivot_core #(
   parameter int CAPACITY = qsmp_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [qsmp_pkg::DATA_W-1:0] req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [qsmp_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_final_res,
   output logic                              rsp_overflow
);
   import qsmp_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NW = IW + 1;
   localparam int SW = 2 * IW;

   // Controller and run state.
   state_type state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [NW-1:0] top_ff, top_in;
   logic [IW-1:0] k_ff, k_in;

   // Partition working registers.
   logic [IW-1:0]       lo_ff, lo_in;
   logic [IW-1:0]       hi_ff, hi_in;
   logic [IW-1:0]       i_ff, i_in;
   logic [NW-1:0]       j_ff, j_in;
   logic [DATA_W-1:0]   pivot_ff, pivot_in;
   logic [DATA_W-1:0]   vj_ff, vj_in;

   // Element memory and range stack memory.
   logic [DATA_W-1:0] elem_mem [CAPACITY];
   logic [DATA_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [IW-1:0]     mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata;

   logic [SW-1:0]     stack_mem [CAPACITY];
   logic [SW-1:0]     stk_rdata_ff;
   logic              stk_we;
   logic [IW-1:0]     stk_waddr, stk_raddr;
   logic [SW-1:0]     stk_wdata;

   // Derived index arithmetic.
   logic [NW-1:0] lo_x, hi_x, i_x, i_inc, j_inc, k_inc, top_dec, count_dec, mid_sum;
   logic [IW-1:0] mid_cur;
   logic          less, top_room, req_acc, rsp_acc, is_final;

   assign lo_x      = {1'b0, lo_ff};
   assign hi_x      = {1'b0, hi_ff};
   assign i_x       = {1'b0, i_ff};
   assign i_inc     = i_x + 1'b1;
   assign j_inc     = j_ff + 1'b1;
   assign k_inc     = {1'b0, k_ff} + 1'b1;
   assign top_dec   = top_ff - 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign mid_sum   = lo_x + hi_x;
   assign mid_cur   = mid_sum[NW-1:1];
   assign less      = $signed(mem_rdata_ff) < $signed(pivot_ff);
   assign top_room  = top_ff < NW'(CAPACITY);
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign is_final  = (k_inc == count_ff);

   // Port outputs are decoded from registers only, with no path from the inputs.
   assign req_ready        = (state_ff == ST_LOAD);
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_sorted_value = mem_rdata_ff;
   assign rsp_final_res    = is_final;
   assign rsp_overflow     = dropped_ff;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_last) state_in = ST_SORT_INIT;
         end
         ST_SORT_INIT: begin
            state_in = (count_ff < NW'(2)) ? ST_OUT_RD : ST_POP;
         end
         ST_POP: begin
            state_in = (top_ff == '0) ? ST_OUT_RD : ST_POP_WAIT;
         end
         ST_POP_WAIT: state_in = ST_RD_MID;
         ST_RD_MID:   state_in = ST_RD_LO;
         ST_RD_LO:    state_in = ST_SWAP_MID;
         ST_SWAP_MID: state_in = ST_SWAP_LO;
         ST_SWAP_LO:  state_in = ST_SCAN_RD;
         ST_SCAN_RD: begin
            state_in = (j_ff > hi_x) ? ST_FIN_RD : ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (less && (i_inc != j_ff)) state_in = ST_SWAP_A;
            else state_in = ST_SCAN_RD;
         end
         ST_SWAP_A:   state_in = ST_SWAP_B;
         ST_SWAP_B:   state_in = ST_SCAN_RD;
         ST_FIN_RD: begin
            state_in = (i_ff == lo_ff) ? ST_PUSH_R : ST_FIN_A;
         end
         ST_FIN_A:    state_in = ST_FIN_B;
         ST_FIN_B:    state_in = ST_PUSH_R;
         ST_PUSH_R:   state_in = ST_PUSH_L;
         ST_PUSH_L:   state_in = ST_POP;
         ST_OUT_RD:   state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_acc && is_final) state_in = ST_LOAD;
         end
         default:     state_in = ST_LOAD;
      endcase
   end

   // Datapath controls and register next values for each state.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      top_in     = top_ff;
      k_in       = k_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      pivot_in   = pivot_ff;
      vj_in      = vj_ff;
      mem_we     = 1'b0;
      mem_waddr  = lo_ff;
      mem_wdata  = pivot_ff;
      mem_raddr  = k_ff;
      stk_we     = 1'b0;
      stk_waddr  = top_ff[IW-1:0];
      stk_wdata  = {lo_ff, hi_ff};
      stk_raddr  = top_dec[IW-1:0];
      unique case (state_ff)
         ST_LOAD: begin
            // Store while there is room; otherwise drop and remember it.
            if (req_acc) begin
               if (count_ff < NW'(CAPACITY)) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IW-1:0];
                  mem_wdata = req_value;
                  count_in  = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         ST_SORT_INIT: begin
            // Push the whole buffer as the first range when it holds two or more elements.
            k_in = '0;
            if (count_ff >= NW'(2)) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = {{IW{1'b0}}, count_dec[IW-1:0]};
               top_in    = NW'(1);
            end else begin
               top_in = '0;
            end
         end
         ST_POP: begin
            if (top_ff != '0) top_in = top_dec;
         end
         ST_POP_WAIT: begin
            lo_in = stk_rdata_ff[SW-1:IW];
            hi_in = stk_rdata_ff[IW-1:0];
         end
         ST_RD_MID: begin
            mem_raddr = mid_cur;
         end
         ST_RD_LO: begin
            pivot_in  = mem_rdata_ff;
            mem_raddr = lo_ff;
         end
         ST_SWAP_MID: begin
            // Old front element goes to the middle slot.
            mem_we    = 1'b1;
            mem_waddr = mid_cur;
            mem_wdata = mem_rdata_ff;
         end
         ST_SWAP_LO: begin
            // Pivot goes to the front; scan starts just after it.
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = pivot_ff;
            i_in      = lo_ff;
            j_in      = lo_x + 1'b1;
         end
         ST_SCAN_RD: begin
            mem_raddr = j_ff[IW-1:0];
         end
         ST_SCAN_CMP: begin
            // A smaller element swaps with the first element not below the pivot.
            if (less) begin
               if (i_inc == j_ff) begin
                  i_in = i_inc[IW-1:0];
                  j_in = j_inc;
               end else begin
                  vj_in     = mem_rdata_ff;
                  mem_raddr = i_inc[IW-1:0];
               end
            end else begin
               j_in = j_inc;
            end
         end
         ST_SWAP_A: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[IW-1:0];
            mem_wdata = mem_rdata_ff;
         end
         ST_SWAP_B: begin
            mem_we    = 1'b1;
            mem_waddr = i_inc[IW-1:0];
            mem_wdata = vj_ff;
            i_in      = i_inc[IW-1:0];
            j_in      = j_inc;
         end
         ST_FIN_RD: begin
            mem_raddr = i_ff;
         end
         ST_FIN_A: begin
            // Swap the pivot into its final place: the element there goes to the front.
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = mem_rdata_ff;
         end
         ST_FIN_B: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = pivot_ff;
         end
         ST_PUSH_R: begin
            // Right part first, so the left part is handled first.
            if ((i_inc < hi_x) && top_room) begin
               stk_we    = 1'b1;
               stk_wdata = {i_inc[IW-1:0], hi_ff};
               top_in    = top_ff + 1'b1;
            end
         end
         ST_PUSH_L: begin
            if (((lo_x + 1'b1) < i_x) && top_room) begin
               stk_we    = 1'b1;
               stk_wdata = {lo_ff, i_ff - 1'b1};
               top_in    = top_ff + 1'b1;
            end
         end
         ST_OUT_RD: begin
            mem_raddr = k_ff;
         end
         ST_OUT: begin
            // Fetch the next element as soon as the current one is taken.
            if (rsp_acc) begin
               mem_raddr = k_inc[IW-1:0];
               if (is_final) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  top_in     = '0;
                  k_in       = '0;
               end else begin
                  k_in = k_inc[IW-1:0];
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         top_ff     <= '0;
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         top_ff     <= top_in;
         k_ff       <= k_in;
      end
   end

   // Partition working registers.
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      pivot_ff <= pivot_in;
      vj_ff    <= vj_in;
   end

   // Element memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) elem_mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= elem_mem[mem_raddr];
   end

   // Range stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      stk_rdata_ff <= stack_mem[stk_raddr];
   end

endmodule

// ===== src/qsmp_checker.sv =====
// Port-level checks for the quicksort core, bound to its top level.
module qsmp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_last,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [qsmp_pkg::DATA_W-1:0] rsp_sorted_value,
   input logic                              rsp_final_res,
   input logic                              rsp_overflow
);
   import qsmp_pkg::*;

   logic rsp_acc, req_acc, mid_run;

   assign rsp_acc = rsp_valid && rsp_ready;
   assign req_acc = req_valid && req_ready;
   assign mid_run = rsp_acc && !rsp_final_res;

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && !$past(reset)) |=>
         (rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_final_res)
          && $stable(rsp_overflow)))
      else $error("result changed while stalled");

   // Requests are never taken while a run is being delivered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready during result delivery");

   // The request closing a set stops intake until the run is out.
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_last) |=> !req_ready)
      else $error("request taken after the closing request");

   // Within a run, results come in ascending order.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (mid_run && !$past(reset)) |=>
         (rsp_valid && (rsp_sorted_value >= $past(rsp_sorted_value))))
      else $error("results out of order");

   // The overflow mark is the same on every result of a run.
   a_overflow_run: assert property (@(posedge clock) disable iff (reset)
      (mid_run && !$past(reset)) |=> (rsp_overflow == $past(rsp_overflow)))
      else $error("overflow mark changed within a run");

endmodule

bind quicksort_middle_pivot_core qsmp_checker u_qsmp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_final_res    (rsp_final_res),
   .rsp_overflow     (rsp_overflow)
);
